[sv/wmi_pkg.sv]
`timescale 1ns / 1ps

package wmi_pkg;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NONINV   = 2'd1;
    localparam logic [1:0] STATUS_MOD_ZERO = 2'd2;

    // compare modes of the shared compare-subtract unit
    typedef enum logic {
        OP_SUB    = 1'b0,   // a >= b, diff = a - b
        OP_DOUBLE = 1'b1    // a >= 2*b, used while aligning the divisor
    } wmi_op_t;

endpackage

[sv/word_modular_inverse.sv]
`timescale 1ns / 1ps

// channel  | direction | fields (lowest bit up)
// ---------+-----------+-----------------------------------------------
// s_axis   | in        | tdata: value[W-1:0], modulus[W-1:0], zero pad
// m_axis   | out       | tdata: inverse[W-2:0], zero pad; tuser: status
//
// one item at a time: a shift-subtract divider first reduces |value| mod
// |modulus|, then runs extended euclid on the same unit. each division
// aligns the divisor, subtracts once per quotient bit, then swaps and
// reloads the remainders; a zero or unit modulus skips the divider and goes
// straight to the result. s_tready is high only while idle.
// the finished result sits in an output register, so a new item can be
// taken while m_tready is low. asynchronous reset clears control state only.
module word_modular_inverse
    import wmi_pkg::*;
#(
    parameter int WORD_BITS = 63
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // value, modulus, zero pad
    input  logic [((2*WORD_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // inverse, zero pad
    output logic [((WORD_BITS-1+7)/8)*8-1:0]     m_tdata,
    // status
    output logic [1:0]                           m_tuser
);

    localparam int W  = WORD_BITS;
    localparam int KW = $clog2(WORD_BITS);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_GROW = 8'b0000_0010,
        ST_SUB  = 8'b0000_0100,
        ST_SWAP = 8'b0000_1000,
        ST_LOAD = 8'b0001_0000,
        ST_FIX  = 8'b0010_0000,
        ST_NEG  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [W-1:0]  r0_reg, r0_next;
    logic [W-1:0]  r1_reg, r1_next;
    logic [W-1:0]  s0_reg, s0_next;
    logic [W-1:0]  s1_reg, s1_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W-1:0]  t_reg, t_next;
    logic [W-1:0]  m_reg, m_next;
    logic [KW-1:0] k_reg, k_next;
    logic          neg0_reg, neg0_next;
    logic          neg1_reg, neg1_next;
    logic          vneg_reg, vneg_next;
    logic          reduce_reg, reduce_next;
    logic [W-2:0]  res_inv_reg, res_inv_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic          out_valid_reg, out_valid_next;
    logic [W-2:0]  out_inv_reg, out_inv_next;
    logic [1:0]    out_status_reg, out_status_next;

    logic [W-1:0]  in_value;
    logic [W-1:0]  in_modulus;
    logic [W-1:0]  value_mag;
    logic [W-1:0]  modulus_mag;
    logic          in_xfer;

    wmi_op_t       unit_op;
    logic [W-1:0]  unit_a;
    logic [W-1:0]  unit_b;
    logic          unit_ge;
    logic [W-1:0]  unit_diff;
    logic [W-1:0]  unit_sum;

    // input unpacking and magnitudes
    assign in_value    = s_tdata[W-1:0];
    assign in_modulus  = s_tdata[2*W-1:W];
    assign value_mag   = in_value[W-1] ? (~in_value + 1'b1) : in_value;
    assign modulus_mag = in_modulus[W-1] ? (~in_modulus + 1'b1) : in_modulus;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // operand select for the shared unit
    always_comb
    begin
        unit_op = OP_SUB;
        unit_a  = r0_reg;
        unit_b  = d_reg;
        unique case (state_reg)
            ST_GROW:
            begin
                unit_op = OP_DOUBLE;
            end
            ST_FIX:
            begin
                unit_a = s0_reg;
                unit_b = m_reg;
            end
            ST_NEG:
            begin
                unit_a = m_reg;
                unit_b = s0_reg;
            end
            default:
            begin
                unit_op = OP_SUB;
            end
        endcase
    end

    wmi_shift_sub #(
        .WIDTH(W)
    ) u_shift_sub (
        .op    (unit_op),
        .a     (unit_a),
        .b     (unit_b),
        .add_a (s0_reg),
        .add_b (t_reg),
        .ge    (unit_ge),
        .diff  (unit_diff),
        .sum   (unit_sum)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        r0_next         = r0_reg;
        r1_next         = r1_reg;
        s0_next         = s0_reg;
        s1_next         = s1_reg;
        d_next          = d_reg;
        t_next          = t_reg;
        m_next          = m_reg;
        k_next          = k_reg;
        neg0_next       = neg0_reg;
        neg1_next       = neg1_reg;
        vneg_next       = vneg_reg;
        reduce_next     = reduce_reg;
        res_inv_next    = res_inv_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_inv_next    = out_inv_reg;
        out_status_next = out_status_reg;

        // output register drains on transfer
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    vneg_next    = in_value[W-1];
                    m_next       = modulus_mag;
                    res_inv_next = '0;
                    if (modulus_mag == '0)
                    begin
                        res_status_next = STATUS_MOD_ZERO;
                        state_next      = ST_DONE;
                    end
                    else if (modulus_mag == {{(W-1){1'b0}}, 1'b1})
                    begin
                        res_status_next = STATUS_NONINV;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        // reduce |value| by the modulus first
                        r0_next     = value_mag;
                        d_next      = modulus_mag;
                        k_next      = '0;
                        reduce_next = 1'b1;
                        state_next  = ST_GROW;
                    end
                end
            end
            ST_GROW:
            begin
                // align divisor up to the dividend without exceeding it
                if (unit_ge)
                begin
                    d_next = {d_reg[W-2:0], 1'b0};
                    t_next = {t_reg[W-2:0], 1'b0};
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                // one quotient bit per cycle
                if (unit_ge)
                begin
                    r0_next = unit_diff;
                    if (!reduce_reg)
                    begin
                        s0_next = unit_sum;
                    end
                end
                d_next = {1'b0, d_reg[W-1:1]};
                t_next = {1'b0, t_reg[W-1:1]};
                if (k_reg == '0)
                begin
                    state_next = ST_SWAP;
                end
                else
                begin
                    k_next = k_reg - 1'b1;
                end
            end
            ST_SWAP:
            begin
                if (reduce_reg)
                begin
                    // start euclid on modulus and residue
                    r0_next     = m_reg;
                    r1_next     = r0_reg;
                    s0_next     = '0;
                    s1_next     = {{(W-1){1'b0}}, 1'b1};
                    neg0_next   = 1'b1;
                    neg1_next   = 1'b0;
                    reduce_next = 1'b0;
                end
                else
                begin
                    r0_next   = r1_reg;
                    r1_next   = r0_reg;
                    s0_next   = s1_reg;
                    s1_next   = s0_reg;
                    neg0_next = neg1_reg;
                    neg1_next = ~neg1_reg;
                end
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (r1_reg == '0)
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    d_next     = r1_reg;
                    t_next     = s1_reg;
                    k_next     = '0;
                    state_next = ST_GROW;
                end
            end
            ST_FIX:
            begin
                // gcd check and coefficient into range
                if (r0_reg != {{(W-1){1'b0}}, 1'b1})
                begin
                    res_inv_next    = '0;
                    res_status_next = STATUS_NONINV;
                    state_next      = ST_DONE;
                end
                else
                begin
                    if (unit_ge)
                    begin
                        s0_next = unit_diff;
                    end
                    res_status_next = STATUS_OK;
                    state_next      = ST_NEG;
                end
            end
            ST_NEG:
            begin
                // coefficient sign and value sign cancel when both set
                if ((neg0_reg ^ vneg_reg) && (s0_reg != '0))
                begin
                    res_inv_next = unit_diff[W-2:0];
                end
                else
                begin
                    res_inv_next = s0_reg[W-2:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_inv_next    = res_inv_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        r0_reg         <= r0_next;
        r1_reg         <= r1_next;
        s0_reg         <= s0_next;
        s1_reg         <= s1_next;
        d_reg          <= d_next;
        t_reg          <= t_next;
        m_reg          <= m_next;
        k_reg          <= k_next;
        neg0_reg       <= neg0_next;
        neg1_reg       <= neg1_next;
        vneg_reg       <= vneg_next;
        reduce_reg     <= reduce_next;
        res_inv_reg    <= res_inv_next;
        res_status_reg <= res_status_next;
        out_inv_reg    <= out_inv_next;
        out_status_reg <= out_status_next;
    end

    // output packing
    always_comb
    begin
        m_tdata        = '0;
        m_tdata[W-2:0] = out_inv_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;

endmodule

[sv/wmi_shift_sub.sv]
`timescale 1ns / 1ps

module wmi_shift_sub
    import wmi_pkg::*;
#(
    parameter int WIDTH = 63
)
(
    input  wmi_op_t          op,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] add_a,
    input  logic [WIDTH-1:0] add_b,
    output logic             ge,
    output logic [WIDTH-1:0] diff,
    output logic [WIDTH-1:0] sum
);

    logic [WIDTH:0] a_ext;
    logic [WIDTH:0] b_ext;
    logic [WIDTH:0] diff_full;

    // subtrahend is b or b shifted up by one, one bit of headroom
    always_comb
    begin
        a_ext = {1'b0, a};
        if (op == OP_DOUBLE)
        begin
            b_ext = {b, 1'b0};
        end
        else
        begin
            b_ext = {1'b0, b};
        end
        diff_full = a_ext - b_ext;
        ge        = (a_ext >= b_ext);
        diff      = diff_full[WIDTH-1:0];
    end

    // coefficient accumulate, bounded by the modulus
    assign sum = add_a + add_b;

endmodule

[verif/word_modular_inverse_checker.sv]
`timescale 1ns / 1ps

module word_modular_inverse_checker
    import wmi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // value, modulus, zero pad
    input  logic [127:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // inverse, zero pad
    input  logic [63:0]  m_tdata,
    // status
    input  logic [1:0]   m_tuser,
    output int           fail_count,
    output int           pending_count
);

    typedef struct packed {
        logic [61:0] inverse;
        logic [1:0]  status;
    } inverse_result_t;

    inverse_result_t pending_inverses[$];
    int              fails = 0;

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    // two's complement magnitude; the most negative pattern maps to 2^62
    function automatic logic [62:0] magnitude(input logic [62:0] raw);
        return raw[62] ? (~raw + 63'd1) : raw;
    endfunction

    // reduce, extended euclid, then fold in the sign of the value
    function automatic inverse_result_t compute_inverse(input logic [62:0] value,
                                                        input logic [62:0] modulus);
        logic [63:0]     a;
        logic [63:0]     m;
        logic [63:0]     r0;
        logic [63:0]     r1;
        logic [63:0]     r2;
        logic [63:0]     s0;
        logic [63:0]     s1;
        logic [63:0]     s2;
        logic [63:0]     q;
        logic [63:0]     inv;
        logic            neg0;
        logic            neg1;
        inverse_result_t res;
        a           = {1'b0, magnitude(value)};
        m           = {1'b0, magnitude(modulus)};
        res.inverse = '0;
        if (m == 64'd0)
        begin
            res.status = STATUS_MOD_ZERO;
        end
        else if (m == 64'd1)
        begin
            res.status = STATUS_NONINV;
        end
        else
        begin
            a    = a % m;
            r0   = m;
            r1   = a;
            s0   = 64'd0;
            s1   = 64'd1;
            neg0 = 1'b1;
            neg1 = 1'b0;
            // coefficient magnitudes alternate in sign and do not exceed m
            while (r1 != 64'd0)
            begin
                q    = r0 / r1;
                r2   = r0 - q * r1;
                s2   = s0 + q * s1;
                r0   = r1;
                s0   = s1;
                neg0 = neg1;
                r1   = r2;
                s1   = s2;
                neg1 = !neg1;
            end
            s0  = s0 % m;
            inv = (neg0 && s0 != 64'd0) ? m - s0 : s0;
            if (r0 == 64'd1)
            begin
                if (value[62] && inv != 64'd0)
                    inv = m - inv;
                res.inverse = inv[61:0];
                res.status  = STATUS_OK;
            end
            else
            begin
                res.status = STATUS_NONINV;
            end
        end
        return res;
    endfunction

    // compare result transfers first, then queue the prediction for input transfers
    always @(posedge clk)
    begin : watch
        inverse_result_t got;
        inverse_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.inverse = m_tdata[61:0];
                got.status  = m_tuser;
                if (pending_inverses.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result inverse %0d status %0d",
                                 $realtime, got.inverse, got.status);
                end
                else
                begin
                    want = pending_inverses.pop_front();
                    if (got != want || m_tdata[63:62] != 2'b00)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: mismatch inverse exp %0d got %0d, status exp %0d got %0d, pad %b",
                                     $realtime, want.inverse, got.inverse, want.status,
                                     got.status, m_tdata[63:62]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_inverses.push_back(compute_inverse(s_tdata[62:0], s_tdata[125:63]));
        end
        fail_count    <= fails;
        pending_count <= pending_inverses.size();
    end

endmodule

[verif/word_modular_inverse_tb.sv]
`timescale 1ns / 1ps

module word_modular_inverse_tb;

    localparam int          WORD_BITS    = 63;
    localparam int          RANDOM_ITEMS = 700;
    localparam int          IDLE_LIMIT   = 20000;
    localparam logic [62:0] MAX_POS      = 63'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] MOST_NEG     = 63'h4000_0000_0000_0000;
    localparam logic [62:0] FIB_89       = 63'd1779979416004714189;
    localparam logic [62:0] FIB_90       = 63'd2880067194370816120;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;
    int           fail_count;
    int           pending_count;
    int           sender_idle_pct = 24;
    int           recv_idle_pct   = 47;
    int           idle_cycles;

    word_modular_inverse #(
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    word_modular_inverse_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // stop if nothing transfers for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // one operand pair, with random gaps before it; valid stays high into the next
    task automatic send_operands(input logic [62:0] value, input logic [62:0] modulus);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, modulus, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // full-width, corner, and small, 32-bit or shifted operands, the last three with random sign
    function automatic logic [62:0] random_operand();
        logic [62:0] r;
        r = 63'({$urandom, $urandom});
        case ($urandom_range(9))
            0, 1, 2, 3: return r;
            4, 5:       r = 63'($urandom_range(0, 1000));
            6:          r = 63'($urandom);
            7:          r = r >> $urandom_range(1, 62);
            default:
            begin
                case ($urandom_range(5))
                    0:       return '0;
                    1:       return 63'd1;
                    2:       return '1;
                    3:       return MAX_POS;
                    4:       return -MAX_POS;
                    default: return MOST_NEG;
                endcase
            end
        endcase
        return $urandom_range(1) ? -r : r;
    endfunction

    task automatic random_pair(output logic [62:0] value, output logic [62:0] modulus);
        int unsigned factor;
        int unsigned steps;
        logic [63:0] fa;
        logic [63:0] fb;
        logic [63:0] ft;
        case ($urandom_range(9))
            // shared factor, never invertible
            7:
            begin
                factor  = $urandom_range(2, 60);
                value   = 63'(factor) * 63'($urandom_range(0, 1000000));
                modulus = 63'(factor) * 63'($urandom_range(1, 1000000));
            end
            // value near the modulus
            8:
            begin
                modulus = random_operand();
                case ($urandom_range(3))
                    0:       value = modulus;
                    1:       value = -modulus;
                    2:       value = modulus + 63'd1;
                    default: value = modulus - 63'd1;
                endcase
            end
            // consecutive fibonacci numbers, the longest euclid runs
            9:
            begin
                steps = $urandom_range(3, 90);
                fa    = 64'd0;
                fb    = 64'd1;
                repeat (steps - 1)
                begin
                    ft = fa + fb;
                    fa = fb;
                    fb = ft;
                end
                value   = $urandom_range(1) ? -fa[62:0] : fa[62:0];
                modulus = $urandom_range(1) ? -fb[62:0] : fb[62:0];
            end
            default:
            begin
                value   = random_operand();
                modulus = random_operand();
            end
        endcase
    endtask

    initial
    begin
        logic [62:0] value;
        logic [62:0] modulus;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // zero and unit modulus
        send_operands(63'd0, 63'd0);
        send_operands(MAX_POS, 63'd0);
        send_operands(63'd5, 63'd1);
        send_operands(-63'd5, -63'd1);
        // signs, reduction, zero residue, shared factors
        send_operands(63'd3, 63'd7);
        send_operands(-63'd3, 63'd7);
        send_operands(63'd3, -63'd7);
        send_operands(63'd100, 63'd7);
        send_operands(63'd0, 63'd7);
        send_operands(63'd14, 63'd7);
        send_operands(63'd6, 63'd9);
        send_operands(63'd1, 63'd2);
        // range extremes
        send_operands(MAX_POS, MAX_POS);
        send_operands(MAX_POS - 63'd1, MAX_POS);
        send_operands(-MAX_POS, 63'd1000003);
        send_operands(-63'd1, MAX_POS);
        // most negative pattern on either operand
        send_operands(MOST_NEG, 63'd1000003);
        send_operands(63'd12345, MOST_NEG);
        send_operands(MOST_NEG, MOST_NEG);
        // longest euclid chain and alternating bit patterns
        send_operands(FIB_89, FIB_90);
        send_operands(-FIB_89, -FIB_90);
        send_operands(63'h2AAA_AAAA_AAAA_AAAA, 63'h1FFF_FFFF_FFFF_FFFF);
        send_operands(63'h1555_5555_5555_5555, 63'h3555_5555_5555_5555);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                sender_idle_pct = 47;
                recv_idle_pct   = 24;
            end
            if (n == 2 * RANDOM_ITEMS / 3)
            begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            random_pair(value, modulus);
            send_operands(value, modulus);
        end
        s_tvalid <= 1'b0;

        // drain, then a short quiet period
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
